FILE: src/iphp_pkg.sv
// shared types and constants for the ip transport header parser
// no dependencies
package iphp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] VER_V4 = 4'd4;
    localparam logic [3:0] VER_V6 = 4'd6;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;
    localparam logic [5:0] V6_HDR = 6'd40;
    localparam logic [5:0] SMALL_HDR = 6'd8;

    localparam logic [1:0] ST_PORTS_VALID = 2'd0;
    localparam logic [1:0] ST_NO_PORTS = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_V4,
        MODE_V6
    } t_mode;

    typedef struct packed {
        logic [1:0]   status;
        logic [3:0]   ip_version;
        logic [7:0]   protocol;
        logic [16:0]  source_port;
        logic [15:0]  destination_port;
        logic [6:0]   header_length;
        logic [16:0]  packet_length;
        logic [16:0]  data_length;
        logic [127:0] src_addr;
        logic [127:0] dst_addr;
    } t_summary;

endpackage

FILE: src/iphp_front.sv
// byte parser: latches header fields by offset and builds a packet summary
// depends on iphp_pkg
module iphp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_sum_push,
    output iphp_pkg::t_summary o_sum
);

    logic                               r_v6_en;
    logic [iphp_pkg::COUNT_WIDTH-1:0]   r_count, n_count;
    logic [3:0]                         r_ver, n_ver;
    logic [5:0]                         r_ihb, n_ihb;
    logic [7:0]                         r_proto, n_proto;
    logic                               r_frag, n_frag;
    logic [15:0]                        r_len, n_len;
    logic [127:0]                       r_sa, n_sa;
    logic [127:0]                       r_da, n_da;
    logic [5:0]                         r_thb, n_thb;
    logic [15:0]                        r_pw0, n_pw0;
    logic [15:0]                        r_pw1, n_pw1;

    iphp_pkg::t_mode mode;
    logic [iphp_pkg::COUNT_WIDTH-1:0] off, rel;
    logic       sa_we, da_we;
    logic [3:0] sa_idx, da_idx;
    logic [5:0] tlen;
    logic [1:0] kind;
    logic [6:0] hdr;
    logic [16:0] plen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_v6_en <= i_cfg_wdata;
        end
    end

    always_comb begin
        off = r_count;
        n_count = r_count;
        n_ver = r_ver;
        n_ihb = r_ihb;
        n_proto = r_proto;
        n_frag = r_frag;
        n_len = r_len;
        n_sa = r_sa;
        n_da = r_da;
        n_thb = r_thb;
        n_pw0 = r_pw0;
        n_pw1 = r_pw1;
        sa_we = 1'b0;
        da_we = 1'b0;
        sa_idx = '0;
        da_idx = '0;
        rel = '0;
        if (off == '0) begin
            n_ver = i_data_byte[7:4];
            if (n_ver == iphp_pkg::VER_V4) begin
                n_ihb = {i_data_byte[3:0], 2'b00};
            end else if (n_ver == iphp_pkg::VER_V6) begin
                n_ihb = iphp_pkg::V6_HDR;
            end else begin
                n_ihb = '0;
            end
        end
        if (n_ver == iphp_pkg::VER_V4) begin
            mode = iphp_pkg::MODE_V4;
        end else if (n_ver == iphp_pkg::VER_V6 && r_v6_en) begin
            mode = iphp_pkg::MODE_V6;
        end else begin
            mode = iphp_pkg::MODE_NONE;
        end
        if (mode == iphp_pkg::MODE_V4) begin
            if (off == 2) n_len[15:8] = i_data_byte;
            else if (off == 3) n_len[7:0] = i_data_byte;
            else if (off == 6) begin
                if (i_data_byte[4:0] != '0) n_frag = 1'b1;
            end else if (off == 7) begin
                if (i_data_byte != '0) n_frag = 1'b1;
            end else if (off == 9) n_proto = i_data_byte;
            else if (off >= 12 && off <= 15) begin
                sa_we = 1'b1;
                sa_idx = off[3:0];
            end else if (off >= 16 && off <= 19) begin
                da_we = 1'b1;
                da_idx = off[3:0] - 4'd4;
            end
        end else if (mode == iphp_pkg::MODE_V6) begin
            if (off == 4) n_len[15:8] = i_data_byte;
            else if (off == 5) n_len[7:0] = i_data_byte;
            else if (off == 6) n_proto = i_data_byte;
            else if (off >= 8 && off <= 23) begin
                sa_we = 1'b1;
                sa_idx = off[3:0] - 4'd8;
            end else if (off >= 24 && off <= 39) begin
                da_we = 1'b1;
                da_idx = off[3:0] - 4'd8;
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (sa_we && sa_idx == i[3:0]) n_sa[127-8*i -: 8] = i_data_byte;
            if (da_we && da_idx == i[3:0]) n_da[127-8*i -: 8] = i_data_byte;
        end
        if (mode != iphp_pkg::MODE_NONE && off >= {{(iphp_pkg::COUNT_WIDTH-6){1'b0}}, n_ihb})
        begin
            rel = off - {{(iphp_pkg::COUNT_WIDTH-6){1'b0}}, n_ihb};
            if (rel == 0) n_pw0[15:8] = i_data_byte;
            else if (rel == 1) n_pw0[7:0] = i_data_byte;
            else if (rel == 2) n_pw1[15:8] = i_data_byte;
            else if (rel == 3) n_pw1[7:0] = i_data_byte;
            else if (rel == 12) n_thb = {i_data_byte[7:4], 2'b00};
        end
        if (r_count != iphp_pkg::COUNT_MAX) n_count = r_count + 1'b1;

        // summary from the updated state
        tlen = '0;
        kind = 2'd0;
        if (mode == iphp_pkg::MODE_V6 || !n_frag) begin
            if (n_proto == iphp_pkg::PROTO_TCP) begin
                tlen = n_thb;
                kind = 2'd1;
            end else if (n_proto == iphp_pkg::PROTO_UDP) begin
                tlen = iphp_pkg::SMALL_HDR;
                kind = 2'd1;
            end else if ((mode == iphp_pkg::MODE_V4 && n_proto == iphp_pkg::PROTO_ICMP) ||
                         (mode == iphp_pkg::MODE_V6 && n_proto == iphp_pkg::PROTO_ICMP6)) begin
                tlen = iphp_pkg::SMALL_HDR;
                kind = 2'd2;
            end
        end
        hdr = {1'b0, n_ihb} + {1'b0, tlen};
        plen = (mode == iphp_pkg::MODE_V4) ? {1'b0, n_len}
                                           : {1'b0, n_len} + 17'(iphp_pkg::V6_HDR);
        o_sum = '0;
        o_sum.ip_version = n_ver;
        if (mode == iphp_pkg::MODE_NONE) begin
            o_sum.status = iphp_pkg::ST_UNKNOWN;
        end else begin
            o_sum.status = iphp_pkg::ST_NO_PORTS;
            o_sum.protocol = n_proto;
            o_sum.header_length = hdr;
            o_sum.packet_length = plen;
            o_sum.data_length = (plen >= {10'd0, hdr}) ? plen - {10'd0, hdr} : '0;
            o_sum.src_addr = n_sa;
            o_sum.dst_addr = n_da;
            if (kind != 2'd0 && n_count >= iphp_pkg::COUNT_WIDTH'(hdr)) begin
                o_sum.status = iphp_pkg::ST_PORTS_VALID;
                if (kind == 2'd1) begin
                    o_sum.source_port = {1'b0, n_pw0};
                    o_sum.destination_port = n_pw1;
                end else begin
                    o_sum.source_port = {1'b0, n_pw0} + 17'd1;
                end
            end
        end
    end

    assign o_sum_push = i_accept && i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_sum_push) begin
            r_count <= '0;
            r_ver <= '0;
            r_ihb <= '0;
            r_proto <= '0;
            r_frag <= 1'b0;
            r_len <= '0;
            r_sa <= '0;
            r_da <= '0;
            r_thb <= '0;
            r_pw0 <= '0;
            r_pw1 <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_ver <= n_ver;
            r_ihb <= n_ihb;
            r_proto <= n_proto;
            r_frag <= n_frag;
            r_len <= n_len;
            r_sa <= n_sa;
            r_da <= n_da;
            r_thb <= n_thb;
            r_pw0 <= n_pw0;
            r_pw1 <= n_pw1;
        end
    end

endmodule

FILE: src/iphp_back.sv
// summary queue and result emitter: two results per packet summary
// depends on iphp_pkg
module iphp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_sum_push,
    input  iphp_pkg::t_summary i_sum,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output iphp_pkg::t_summary o_head,
    output logic               o_phase
);

    iphp_pkg::t_summary r_q [iphp_pkg::QUEUE_DEPTH];
    logic [$clog2(iphp_pkg::QUEUE_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(iphp_pkg::QUEUE_DEPTH):0]   r_cnt;
    logic r_phase;
    logic deq;

    assign o_full = (r_cnt == ($clog2(iphp_pkg::QUEUE_DEPTH)+1)'(iphp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head = r_q[r_rp];
    assign o_phase = r_phase;
    assign deq = i_pop && !o_empty && r_phase;

    always_ff @(posedge i_clk) begin
        if (i_sum_push) r_q[r_wp] <= i_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_phase <= 1'b0;
        end else begin
            if (i_sum_push) r_wp <= r_wp + 1'b1;
            if (deq) r_rp <= r_rp + 1'b1;
            if (i_pop && !o_empty) r_phase <= !r_phase;
            if (i_sum_push && !deq) r_cnt <= r_cnt + 1'b1;
            else if (deq && !i_sum_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: src/ip_transport_header_parser_core.sv
// top level of the ip transport header parser
// depends on iphp_pkg, iphp_front, iphp_back
// Takes one packet byte per cycle while not full (IPv4 or IPv6 header first,
// last byte marked) and returns two result transactions per packet: source
// address with the five-tuple summary, then destination address. The front
// parser stalls only when its two-entry summary queue is full, and the output
// side drains one result per cycle.
module ip_transport_header_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         push,
    output logic         full,
    input  logic [7:0]   i_data_byte,
    input  logic         i_last_byte,
    output logic         empty,
    input  logic         pop,
    output logic [1:0]   o_status,
    output logic [3:0]   o_ip_version,
    output logic [7:0]   o_protocol,
    output logic [16:0]  o_source_port,
    output logic [15:0]  o_destination_port,
    output logic [6:0]   o_header_length,
    output logic [16:0]  o_packet_length,
    output logic [16:0]  o_data_length,
    output logic [63:0]  o_address_high,
    output logic [63:0]  o_address_low,
    output logic         o_is_destination,
    output logic         o_last
);

    logic               sum_push;
    iphp_pkg::t_summary sum, head;
    logic               phase;

    iphp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (push && !full),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_sum_push (sum_push),
        .o_sum      (sum)
    );

    iphp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sum_push(sum_push),
        .i_sum     (sum),
        .o_full    (full),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_head    (head),
        .o_phase   (phase)
    );

    assign o_status = head.status;
    assign o_ip_version = head.ip_version;
    assign o_protocol = head.protocol;
    assign o_source_port = head.source_port;
    assign o_destination_port = head.destination_port;
    assign o_header_length = head.header_length;
    assign o_packet_length = head.packet_length;
    assign o_data_length = head.data_length;
    assign o_address_high = phase ? head.dst_addr[127:64] : head.src_addr[127:64];
    assign o_address_low = phase ? head.dst_addr[63:0] : head.src_addr[63:0];
    assign o_is_destination = phase;
    assign o_last = phase;

endmodule

FILE: src/iphp_checker.sv
// port-level checks for the ip transport header parser
// depends on ip_transport_header_parser_core
module iphp_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [16:0] o_source_port,
    input logic [63:0] o_address_high,
    input logic        o_is_destination,
    input logic        o_last
);

    a_last_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last == o_is_destination))
        else $error("last and is_destination differ");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> (!empty && o_last))
        else $error("source result not followed by destination result");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == 2'd2) |-> (o_source_port == '0 && o_address_high == '0))
        else $error("unknown version carries data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_last) && $stable(o_status)))
        else $error("waiting result changed");

endmodule

bind ip_transport_header_parser_core iphp_port_checker u_iphp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_status        (o_status),
    .o_source_port   (o_source_port),
    .o_address_high  (o_address_high),
    .o_is_destination(o_is_destination),
    .o_last          (o_last)
);
